[design/tsf_pkg.sv]
package tsf_pkg;

  // history depth and derived widths
  localparam int DEPTH      = 1024;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int SEEN_W     = $clog2(DEPTH + 1);
  localparam int NUM_TAPS   = 3;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int PEAK_W     = 9;
  localparam int GAP_W      = 10;
  localparam int GAIN_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // arithmetic widths
  localparam int RAW_DLY_W  = ((GAP_W > PEAK_W + 1) ? GAP_W : PEAK_W + 1) + 1;
  localparam int DIFF_W     = SAMPLE_W + 3;
  localparam int P_W        = 27;
  localparam int S_W        = 56;
  localparam int S_FRAC     = 8;
  localparam int PROD_W     = GAIN_W + 1 + DIFF_W;
  localparam int SUM_W      = S_W + 2;

  // register reset values
  localparam logic [PEAK_W-1:0] PEAK_RST = PEAK_W'(64);
  localparam logic [GAP_W-1:0]  GAP_RST  = GAP_W'(32);
  localparam logic [GAIN_W-1:0] GAIN_RST = '0;

  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [SEEN_W-1:0]          seen_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEAK = 2'd0,
    CFG_GAP  = 2'd1,
    CFG_GAIN = 2'd2
  } cfg_idx_t;

  // where a delayed tap takes its value from
  typedef enum logic [1:0] {
    TAP_MEM,
    TAP_CUR,
    TAP_ZERO
  } tap_sel_t;

  // difference beat handed to the accumulator stages
  typedef struct packed {
    logic  valid;
    logic  first;
    diff_t diff;
  } diff_beat_t;

  // delays past the history depth read the oldest entry
  function automatic seen_t clamp_dly(input logic [RAW_DLY_W-1:0] v);
    seen_t r;
    if (32'(v) > DEPTH) r = SEEN_W'(DEPTH);
    else                r = SEEN_W'(v);
    return r;
  endfunction

endpackage

[design/tsf_if.sv]
// sample stream
interface tsf_in_if;
  logic                valid;
  logic                ready;
  tsf_pkg::sample_t    sample;
  logic                first_of_wave;

  modport source (output valid, output sample, output first_of_wave, input ready);
  modport sink   (input valid, input sample, input first_of_wave, output ready);
endinterface

// shaped output stream
interface tsf_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [tsf_pkg::S_W-1:0] trap_out;

  modport source (output valid, output trap_out, input ready);
  modport sink   (input valid, input trap_out, output ready);
endinterface

[design/trapezoidal_shaping_filter_core.sv]
// Trapezoidal shaping filter with pole-zero correction.
// in_ch carries one ADC sample per beat; first_of_wave on a beat starts a new
// waveform, restarting the delay history fill and clearing both running sums for that beat.
// out_ch gives one shaped value (signed, 8 fractional bits) per input beat,
// in order. cfg_we/cfg_index/cfg_wdata write peak length, gap length and the
// pole-zero gain; write them only while no beats are in flight.
// Pipeline: the edge that accepts a sample registers it with the history read;
// then come the difference, the p update with multiply, and the s update into the
// output register, where the result waits until out_ch.ready takes it.
// Throughput: one sample per cycle while out_ch.ready does not stall the pipeline;
// the history banks take one write and three reads per cycle, and each running sum feeds back from its own register.
// Reset: registers return to k=64, g=32, M=0; sums and the fill count are zero,
// so the first sample after reset starts a waveform. No clearing pass runs.
// Stall: when out_ch.ready is low the pipeline holds; empty stages still fill,
// and in_ch.ready drops only once all four stages hold a beat.
module trapezoidal_shaping_filter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  tsf_in_if.sink                            in_ch,
  tsf_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [tsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int NT = tsf_pkg::NUM_TAPS;

  logic [tsf_pkg::PEAK_W-1:0] peak_len_r;
  logic [tsf_pkg::GAP_W-1:0]  gap_len_r;
  logic [tsf_pkg::GAIN_W-1:0] pz_gain_r;

  tsf_pkg::seen_t     seen_r, seen_eff, seen_nxt;
  tsf_pkg::addr_t     wp_r;
  tsf_pkg::seen_t     dly   [NT];
  tsf_pkg::tap_sel_t  sel   [NT];
  tsf_pkg::addr_t     raddr [NT];
  tsf_pkg::sample_t   rdata [NT];
  tsf_pkg::sample_t   tapv  [NT];

  logic                  v1_r, v2_r;
  logic                  first1_r, first2_r;
  tsf_pkg::sample_t      x1_r;
  tsf_pkg::tap_sel_t     sel1_r [NT];
  tsf_pkg::diff_t        d2_r;
  tsf_pkg::diff_t        d_nxt;
  tsf_pkg::diff_beat_t   dbeat;

  logic ready1, ready2, acc_ready, in_acc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_len_r <= tsf_pkg::PEAK_RST;
      gap_len_r  <= tsf_pkg::GAP_RST;
      pz_gain_r  <= tsf_pkg::GAIN_RST;
    end else if (cfg_we) begin
      unique case (tsf_pkg::cfg_idx_t'(cfg_index))
        tsf_pkg::CFG_PEAK: peak_len_r <= cfg_wdata[tsf_pkg::PEAK_W-1:0];
        tsf_pkg::CFG_GAP:  gap_len_r  <= cfg_wdata[tsf_pkg::GAP_W-1:0];
        tsf_pkg::CFG_GAIN: pz_gain_r  <= cfg_wdata[tsf_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign ready2      = !v2_r || acc_ready;
  assign ready1      = !v1_r || ready2;
  assign in_ch.ready = ready1;
  assign in_acc      = in_ch.valid && ready1;

  // tap delays k, g+k, g+2k and their read addresses
  assign seen_eff = in_ch.first_of_wave ? '0 : seen_r;
  assign dly[0]   = tsf_pkg::clamp_dly(tsf_pkg::RAW_DLY_W'(peak_len_r));
  assign dly[1]   = tsf_pkg::clamp_dly(tsf_pkg::RAW_DLY_W'(gap_len_r)
                                       + tsf_pkg::RAW_DLY_W'(peak_len_r));
  assign dly[2]   = tsf_pkg::clamp_dly(tsf_pkg::RAW_DLY_W'(gap_len_r)
                                       + (tsf_pkg::RAW_DLY_W'(peak_len_r) << 1));

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      raddr[i] = wp_r - dly[i][tsf_pkg::ADDR_W-1:0];
      if (dly[i] == '0)          sel[i] = tsf_pkg::TAP_CUR;
      else if (dly[i] > seen_eff) sel[i] = tsf_pkg::TAP_ZERO;
      else                        sel[i] = tsf_pkg::TAP_MEM;
    end
  end

  // fill count saturates at the history depth
  assign seen_nxt = (32'(seen_eff) < tsf_pkg::DEPTH) ? seen_eff + 1'b1 : seen_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      wp_r   <= '0;
    end else if (in_acc) begin
      seen_r <= seen_nxt;
      wp_r   <= wp_r + 1'b1;
    end
  end

  // history: current sample written on accept, taps read the same edge
  tsf_hist_mem u_hist (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp_r),
    .wdata (in_ch.sample),
    .re    (in_acc),
    .raddr (raddr),
    .rdata (rdata)
  );

  // stage 1: sample and tap selects alongside the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ready1) begin
      v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x1_r     <= in_ch.sample;
      first1_r <= in_ch.first_of_wave;
      for (int i = 0; i < NT; i++) begin
        sel1_r[i] <= sel[i];
      end
    end
  end

  // stage 2: d = x - x[n-k] - x[n-g-k] + x[n-g-2k]
  always_comb begin
    for (int i = 0; i < NT; i++) begin
      case (sel1_r[i])
        tsf_pkg::TAP_MEM: tapv[i] = rdata[i];
        tsf_pkg::TAP_CUR: tapv[i] = x1_r;
        default:          tapv[i] = '0;
      endcase
    end
  end

  assign d_nxt = tsf_pkg::DIFF_W'(x1_r) - tsf_pkg::DIFF_W'(tapv[0])
               - tsf_pkg::DIFF_W'(tapv[1]) + tsf_pkg::DIFF_W'(tapv[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ready2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1_r) begin
      d2_r     <= d_nxt;
      first2_r <= first1_r;
    end
  end

  assign dbeat.valid = v2_r;
  assign dbeat.first = first2_r;
  assign dbeat.diff  = d2_r;

  // stages 3 and 4: running sums and output register
  tsf_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .din       (dbeat),
    .pz_gain   (pz_gain_r),
    .acc_ready (acc_ready),
    .out_ch    (out_ch)
  );

  // checks
  a_first_restarts_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.first_of_wave |=> seen_r == tsf_pkg::SEEN_W'(1))
    else $error("fill count not restarted by first beat of waveform");

  a_wp_steps: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> wp_r == tsf_pkg::ADDR_W'($past(wp_r) + 1'b1))
    else $error("write pointer did not advance on accepted beat");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(seen_r) <= tsf_pkg::DEPTH)
    else $error("fill count exceeds history depth");

  a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !ready2 |=> v1_r && $stable(d_nxt))
    else $error("stage 1 beat lost while stage 2 stalled");

endmodule

[design/tsf_hist_mem.sv]
// Sample history: two identical banks, written together, giving three read ports.
module tsf_hist_mem (
  input  logic              clk,
  input  logic              we,
  input  tsf_pkg::addr_t    waddr,
  input  tsf_pkg::sample_t  wdata,
  input  logic              re,
  input  tsf_pkg::addr_t    raddr [tsf_pkg::NUM_TAPS],
  output tsf_pkg::sample_t  rdata [tsf_pkg::NUM_TAPS]
);

  tsf_pkg::sample_t bank_a [tsf_pkg::DEPTH];
  tsf_pkg::sample_t bank_b [tsf_pkg::DEPTH];

  // write port, shared by both banks
  always_ff @(posedge clk) begin
    if (we) begin
      bank_a[waddr] <= wdata;
      bank_b[waddr] <= wdata;
    end
  end

  // registered reads: bank a serves two taps, bank b the third
  always_ff @(posedge clk) begin
    if (re) begin
      rdata[0] <= bank_a[raddr[0]];
      rdata[1] <= bank_a[raddr[1]];
      rdata[2] <= bank_b[raddr[2]];
    end
  end

endmodule

[design/tsf_accum.sv]
// Running sums: p += d, then s += p*256 + M*d, both saturating.
module tsf_accum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsf_pkg::diff_beat_t           din,
  input  logic [tsf_pkg::GAIN_W-1:0]    pz_gain,
  output logic                          acc_ready,
  tsf_out_if.source                     out_ch
);

  localparam int P_W    = tsf_pkg::P_W;
  localparam int S_W    = tsf_pkg::S_W;
  localparam int SUM_W  = tsf_pkg::SUM_W;
  localparam int PROD_W = tsf_pkg::PROD_W;

  logic                     v3_r, v4_r;
  logic                     first3_r;
  logic signed [P_W-1:0]    p3_r;
  logic signed [PROD_W-1:0] prod3_r;
  logic signed [S_W-1:0]    s_r;

  logic                     ready3, ready4;
  logic signed [P_W-1:0]    p_base;
  logic signed [P_W:0]      p_sum;
  logic signed [P_W-1:0]    p_sat;
  logic signed [PROD_W-1:0] prod;
  logic signed [S_W-1:0]    s_base;
  logic signed [SUM_W-1:0]  s_sum;
  logic signed [S_W-1:0]    s_sat;

  // stage handshake, bubbles collapse
  assign ready4    = !v4_r || out_ch.ready;
  assign ready3    = !v3_r || ready4;
  assign acc_ready = ready3;

  // p update and pole-zero product
  assign p_base = din.first ? '0 : p3_r;
  assign p_sum  = (P_W + 1)'(p_base) + (P_W + 1)'(din.diff);
  always_comb begin
    if (p_sum[P_W] != p_sum[P_W-1]) begin
      p_sat = p_sum[P_W] ? {1'b1, {(P_W - 1){1'b0}}} : {1'b0, {(P_W - 1){1'b1}}};
    end else begin
      p_sat = p_sum[P_W-1:0];
    end
  end
  assign prod = $signed({1'b0, pz_gain}) * din.diff;

  // p register doubles as the running difference sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      p3_r <= '0;
    end else if (ready3) begin
      v3_r <= din.valid;
      if (din.valid) begin
        p3_r <= p_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && din.valid) begin
      prod3_r  <= prod;
      first3_r <= din.first;
    end
  end

  // s update
  assign s_base = first3_r ? '0 : s_r;
  assign s_sum  = SUM_W'(s_base) + (SUM_W'(p3_r) <<< tsf_pkg::S_FRAC) + SUM_W'(prod3_r);
  always_comb begin
    if ((s_sum[SUM_W-1] != s_sum[S_W-1]) || (s_sum[SUM_W-2] != s_sum[S_W-1])) begin
      s_sat = s_sum[SUM_W-1] ? {1'b1, {(S_W - 1){1'b0}}} : {1'b0, {(S_W - 1){1'b1}}};
    end else begin
      s_sat = s_sum[S_W-1:0];
    end
  end

  // output register holds the trapezoid sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      s_r  <= '0;
    end else if (ready4) begin
      v4_r <= v3_r;
      if (v3_r) begin
        s_r <= s_sat;
      end
    end
  end

  assign out_ch.valid    = v4_r;
  assign out_ch.trap_out = s_r;

endmodule
